@@ design/lzcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzcd_pkg
// Shared types and constants for the LZSS chunk decoder.
// ----------------------------------------------------------------------------
package lzcd_pkg;

  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned WIN_AW    = 12;
  localparam int unsigned LEN_W     = 5;

  typedef logic [7:0]        byte_t;
  typedef logic [WIN_AW-1:0] win_addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic accept;
    logic ld_flags;
    logic adv_flag;
    logic ld_tok;
    logic emit_lit;
    logic emit_end;
    logic copy_start;
    logic rd_issue;
    logic copy_fire;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic flag_hit;
    logic flag_wrap;
    logic src_zero;
    logic rd_more;
    logic emit_last;
    logic q_valid;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

@@ design/lzcd_if.sv @@
// ----------------------------------------------------------------------------
// lzcd_in_if / lzcd_out_if
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lzcd_in_if;
  logic                valid;
  logic                ready;
  lzcd_pkg::byte_t     in_byte;
  logic                chunk_start;

  modport source (output valid, output in_byte, output chunk_start, input ready);
  modport sink   (input valid, input in_byte, input chunk_start, output ready);
endinterface

interface lzcd_out_if;
  logic                valid;
  logic                ready;
  lzcd_pkg::byte_t     out_byte;
  logic                byte_valid;
  logic                run_last;
  logic                stream_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input stream_end, output ready);
endinterface

@@ design/lzss_chunk_decoder_top.sv @@
// Output: a literal is shown in the cycle after its transfer.
// Input: flag and token bytes are taken while the output is free; a copy token
//   stops input until its length+2 bytes are emitted (one window port).
// Reset: synchronous, active low; a clearing pass then zeroes the whole
//   history window, during which no input is taken (configuration still is).
// ----------------------------------------------------------------------------
// lzss_chunk_decoder_top
// LZSS chunk decoder with optional positional descrambling and 4 KiB window.
// ----------------------------------------------------------------------------
module lzss_chunk_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  lzcd_in_if.sink   in_ch,
  lzcd_out_if.source out_ch
);

  lzcd_pkg::cmd_t cmd;
  lzcd_pkg::sts_t sts;

  lzcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzcd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_byte     (in_ch.in_byte),
    .chunk_start (in_ch.chunk_start),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .run_last    (out_ch.run_last),
    .stream_end  (out_ch.stream_end)
  );

endmodule

@@ design/lzcd_ram.sv @@
// ----------------------------------------------------------------------------
// lzcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lzcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzcd_ctrl
// Controller: window clearing, stream parsing phases and the copy sequence.
// ----------------------------------------------------------------------------
module lzcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzcd_pkg::sts_t sts,
  output lzcd_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] phase_eff;

  assign phase_eff = sts.start ? PH_FLAG : phase_r;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          case (phase_eff)
            PH_FLAG: begin
              cmd.ld_flags = 1'b1;
              phase_nxt    = PH_ITEM;
            end
            PH_ITEM: begin
              if (!sts.flag_hit) begin
                cmd.emit_lit = 1'b1;
                cmd.adv_flag = 1'b1;
                phase_nxt    = sts.flag_wrap ? PH_FLAG : PH_ITEM;
              end else begin
                cmd.ld_tok = 1'b1;
                phase_nxt  = PH_HIGH;
              end
            end
            PH_HIGH: begin
              if (sts.src_zero) begin
                cmd.emit_end = 1'b1;
                phase_nxt    = PH_DONE;
              end else begin
                cmd.copy_start = 1'b1;
                cmd.adv_flag   = 1'b1;
                phase_nxt      = sts.flag_wrap ? PH_FLAG : PH_ITEM;
                state_nxt      = ST_COPY;
              end
            end
            default: begin
              phase_nxt = PH_DONE;
            end
          endcase
        end
      end
      ST_COPY: begin
        cmd.copy_fire = sts.q_valid && sts.out_free;
        cmd.rd_issue  = sts.rd_more && (!sts.q_valid || cmd.copy_fire);
        if (cmd.copy_fire && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= PH_FLAG;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_copy_enter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_start |=> state_r == ST_COPY)
    else $error("copy start did not enter the copy state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_COPY) |-> !in_ready)
    else $error("input ready while clearing or copying");
`endif

endmodule

@@ design/lzcd_dp.sv @@
// ----------------------------------------------------------------------------
// lzcd_dp
// Datapath: descrambler, parse registers, history window and result register.
// ----------------------------------------------------------------------------
module lzcd_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  lzcd_pkg::byte_t in_byte,
  input  logic            chunk_start,
  input  lzcd_pkg::cmd_t  cmd,
  output lzcd_pkg::sts_t  sts,
  input  logic            out_ready,
  output logic            out_valid,
  output lzcd_pkg::byte_t out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            stream_end
);

  logic                 desc_en_r;
  lzcd_pkg::byte_t      pos_r, pos_nxt, pos_eff;
  lzcd_pkg::win_addr_t  wp_r, wp_nxt, wp_eff;
  lzcd_pkg::byte_t      flags_r, flags_nxt;
  lzcd_pkg::byte_t      fsel_r, fsel_nxt;
  lzcd_pkg::byte_t      tok_lo_r, tok_lo_nxt;
  lzcd_pkg::win_addr_t  src_r, src_nxt, src_in;
  lzcd_pkg::len_t       rd_left_r, rd_left_nxt;
  lzcd_pkg::len_t       emit_left_r, emit_left_nxt;
  lzcd_pkg::len_t       len_in;
  lzcd_pkg::win_addr_t  clr_addr_r;
  logic                 q_valid_r, q_valid_nxt;
  logic                 byp_hit_r;
  lzcd_pkg::byte_t      byp_data_r;
  lzcd_pkg::byte_t      ram_q, q_eff;
  lzcd_pkg::byte_t      diff, b;
  logic                 ram_we;
  lzcd_pkg::win_addr_t  ram_waddr;
  lzcd_pkg::byte_t      ram_wdata;
  logic                 out_valid_r, out_valid_nxt;
  lzcd_pkg::byte_t      out_byte_r;
  logic                 byte_valid_r, run_last_r, stream_end_r;
  logic                 out_load;

  assign pos_eff = chunk_start ? 8'd0 : pos_r;
  assign wp_eff  = chunk_start ? lzcd_pkg::win_addr_t'(1) : wp_r;
  assign diff    = in_byte - pos_eff;
  assign b       = desc_en_r ? (diff ^ pos_eff) : in_byte;
  assign src_in  = {b, tok_lo_r[7:4]};
  assign len_in  = lzcd_pkg::len_t'(tok_lo_r[3:0]) + lzcd_pkg::len_t'(2);
  assign q_eff   = byp_hit_r ? byp_data_r : ram_q;

  assign sts.start     = chunk_start;
  assign sts.flag_hit  = |(flags_r & fsel_r);
  assign sts.flag_wrap = fsel_r[7];
  assign sts.src_zero  = (src_in == '0);
  assign sts.rd_more   = (rd_left_r != '0);
  assign sts.emit_last = (emit_left_r == lzcd_pkg::len_t'(1));
  assign sts.q_valid   = q_valid_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_last  = (clr_addr_r == '1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = q_eff;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.emit_lit) begin
      ram_we    = 1'b1;
      ram_waddr = wp_eff;
      ram_wdata = b;
    end else if (cmd.copy_fire) begin
      ram_we = 1'b1;
    end
  end

  lzcd_ram #(
    .WIDTH (8),
    .DEPTH (lzcd_pkg::WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (src_r),
    .rdata (ram_q)
  );

  always_comb begin
    pos_nxt       = pos_r;
    wp_nxt        = wp_r;
    flags_nxt     = flags_r;
    fsel_nxt      = fsel_r;
    tok_lo_nxt    = tok_lo_r;
    src_nxt       = src_r;
    rd_left_nxt   = rd_left_r;
    emit_left_nxt = emit_left_r;
    q_valid_nxt   = q_valid_r;
    if (cmd.accept) begin
      pos_nxt = pos_eff + 8'd1;
      wp_nxt  = wp_eff;
    end
    if (cmd.ld_flags) begin
      flags_nxt = b;
      fsel_nxt  = 8'd1;
    end
    if (cmd.adv_flag) begin
      fsel_nxt = fsel_r[7] ? 8'd1 : {fsel_r[6:0], 1'b0};
    end
    if (cmd.ld_tok) begin
      tok_lo_nxt = b;
    end
    if (cmd.emit_lit) begin
      wp_nxt = wp_eff + lzcd_pkg::win_addr_t'(1);
    end
    if (cmd.copy_start) begin
      src_nxt       = src_in;
      rd_left_nxt   = len_in;
      emit_left_nxt = len_in;
    end
    if (cmd.copy_fire) begin
      wp_nxt        = wp_r + lzcd_pkg::win_addr_t'(1);
      emit_left_nxt = emit_left_r - lzcd_pkg::len_t'(1);
      q_valid_nxt   = 1'b0;
    end
    if (cmd.rd_issue) begin
      src_nxt     = src_r + lzcd_pkg::win_addr_t'(1);
      rd_left_nxt = rd_left_r - lzcd_pkg::len_t'(1);
      q_valid_nxt = 1'b1;
    end
  end

  assign out_load      = cmd.emit_lit || cmd.emit_end || cmd.copy_fire;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_en_r   <= 1'b0;
      pos_r       <= '0;
      wp_r        <= lzcd_pkg::win_addr_t'(1);
      flags_r     <= '0;
      fsel_r      <= 8'd1;
      rd_left_r   <= '0;
      emit_left_r <= '0;
      clr_addr_r  <= '0;
      q_valid_r   <= 1'b0;
      byp_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_en_r <= cfg_wdata;
      end
      pos_r       <= pos_nxt;
      wp_r        <= wp_nxt;
      flags_r     <= flags_nxt;
      fsel_r      <= fsel_nxt;
      rd_left_r   <= rd_left_nxt;
      emit_left_r <= emit_left_nxt;
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + lzcd_pkg::win_addr_t'(1);
      end
      if (cmd.rd_issue) begin
        byp_hit_r <= cmd.copy_fire && (wp_r == src_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_lo_r <= tok_lo_nxt;
    src_r    <= src_nxt;
    if (cmd.rd_issue) begin
      byp_data_r <= q_eff;
    end
    if (out_load) begin
      out_byte_r   <= cmd.emit_end ? 8'd0 : (cmd.emit_lit ? b : q_eff);
      byte_valid_r <= !cmd.emit_end;
      run_last_r   <= cmd.copy_fire ? sts.emit_last : 1'b1;
      stream_end_r <= cmd.emit_end;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign byte_valid = byte_valid_r;
  assign run_last   = run_last_r;
  assign stream_end = stream_end_r;

`ifndef SYNTHESIS
  a_fire_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_fire |-> q_valid_r)
    else $error("copy byte emitted without window data");
  a_reads_lead: assert property (@(posedge clk) disable iff (!rst_n)
    emit_left_r >= rd_left_r)
    else $error("more window reads pending than bytes left to emit");
  a_fsel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(fsel_r))
    else $error("flag select lost its single bit");
`endif

endmodule

@@ dv/tb_lzss_chunk_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_chunk_decoder_top
// Self-checking bench for the LZSS chunk decoder. A queue-fed driver sends
// compressed chunks over the input channel; an in-bench decoder works out
// every decoded byte and end marker, and a monitor compares each output
// transfer against it. Phases switch descrambling and the channel idling.
// ----------------------------------------------------------------------------
module tb_lzss_chunk_decoder_top;

  localparam int unsigned STALL_LIMIT = 20000;

  typedef enum logic [1:0] {WANT_FLAGS, WANT_ITEM, WANT_HIGH, CHUNK_DONE} parse_phase_t;

  typedef struct packed {
    lzcd_pkg::byte_t data;
    logic            start;
  } chunk_byte_t;

  typedef struct packed {
    lzcd_pkg::byte_t data;
    logic            is_byte;
    logic            last;
    logic            fin;
  } decoded_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  lzcd_in_if  in_if ();
  lzcd_out_if out_if ();

  lzss_chunk_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  chunk_byte_t compressed_q[$];
  decoded_t    decoded_q[$];

  // decoder state
  lzcd_pkg::byte_t     window [lzcd_pkg::WIN_DEPTH];
  lzcd_pkg::win_addr_t wr_ptr;
  lzcd_pkg::byte_t     flags;
  logic [8:0]          flag_sel;
  parse_phase_t        phase;
  lzcd_pkg::byte_t     tok_lo;
  lzcd_pkg::byte_t     pos;
  logic                descramble_on;

  // chunk builder state
  lzcd_pkg::byte_t     gen_pos;
  lzcd_pkg::win_addr_t gen_wr;
  int                  queued_count;

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void expect_result(lzcd_pkg::byte_t data, logic is_byte, logic last,
                                        logic fin);
    decoded_t r;
    r = '{data, is_byte, last, fin};
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void queue_raw(lzcd_pkg::byte_t data, logic start);
    chunk_byte_t c;
    c = '{data, start};
    compressed_q = {compressed_q, c};
  endfunction

  function automatic void next_flag();
    flag_sel = flag_sel << 1;
    if (flag_sel[8]) begin
      flag_sel = 9'd1;
      phase = WANT_FLAGS;
    end else begin
      phase = WANT_ITEM;
    end
  endfunction

  function automatic void decode_byte(lzcd_pkg::byte_t raw, logic start);
    lzcd_pkg::byte_t     b;
    lzcd_pkg::byte_t     v;
    lzcd_pkg::win_addr_t src;
    int unsigned         len;
    int unsigned         i;
    if (start) begin
      phase = WANT_FLAGS;
      pos = '0;
      wr_ptr = lzcd_pkg::win_addr_t'(1);
      flag_sel = 9'd1;
    end
    b = descramble_on ? ((raw - pos) ^ pos) : raw;
    pos = pos + 8'd1;
    case (phase)
      WANT_FLAGS: begin
        flags = b;
        flag_sel = 9'd1;
        phase = WANT_ITEM;
      end
      WANT_ITEM: begin
        if ((flags & flag_sel[7:0]) == 8'h00) begin
          expect_result(b, 1'b1, 1'b1, 1'b0);
          window[wr_ptr] = b;
          wr_ptr = wr_ptr + 1'b1;
          next_flag();
        end else begin
          tok_lo = b;
          phase = WANT_HIGH;
        end
      end
      WANT_HIGH: begin
        src = {b, tok_lo[7:4]};
        len = tok_lo[3:0] + 2;
        if (src == '0) begin
          expect_result(8'h00, 1'b0, 1'b1, 1'b1);
          phase = CHUNK_DONE;
        end else begin
          for (i = 0; i < len; i++) begin
            v = window[src];
            expect_result(v, 1'b1, (i == len - 1), 1'b0);
            window[wr_ptr] = v;
            wr_ptr = wr_ptr + 1'b1;
            src = src + 1'b1;
          end
          next_flag();
        end
      end
      default: ;
    endcase
  endfunction

  // scramble a plain byte so that the block's descrambler restores it
  function automatic void queue_byte(lzcd_pkg::byte_t plain, logic start);
    lzcd_pkg::byte_t raw;
    if (start) begin
      gen_pos = '0;
      gen_wr = lzcd_pkg::win_addr_t'(1);
    end
    raw = descramble_on ? ((plain ^ gen_pos) + gen_pos) : plain;
    queue_raw(raw, start);
    gen_pos = gen_pos + 8'd1;
    queued_count++;
  endfunction

  task automatic queue_chunk(int groups, bit terminate);
    lzcd_pkg::byte_t     fl;
    lzcd_pkg::win_addr_t off;
    logic [3:0]          len_code;
    int                  stop;
    int                  back_off;
    int                  g;
    int                  k;
    for (g = 0; g < groups; g++) begin
      fl = lzcd_pkg::byte_t'($urandom_range(255));
      stop = 7;
      if (terminate && g == groups - 1) begin
        stop = $urandom_range(7);
        fl[stop] = 1'b1;
      end
      queue_byte(fl, g == 0);
      for (k = 0; k <= stop; k++) begin
        if (!fl[k]) begin
          queue_byte(lzcd_pkg::byte_t'($urandom_range(255)), 1'b0);
          gen_wr = gen_wr + 1'b1;
        end else if (terminate && g == groups - 1 && k == stop) begin
          queue_byte(lzcd_pkg::byte_t'($urandom_range(15)), 1'b0);
          queue_byte(8'h00, 1'b0);
        end else begin
          back_off = ($urandom_range(3) == 0) ? $urandom_range(4095, 1) :
                                                $urandom_range(40, 1);
          off = gen_wr - lzcd_pkg::win_addr_t'(back_off);
          if (off == '0)
            off = lzcd_pkg::win_addr_t'(1);
          len_code = 4'($urandom_range(15));
          queue_byte({off[3:0], len_code}, 1'b0);
          queue_byte(off[11:4], 1'b0);
          gen_wr = gen_wr + len_code + 2'd2;
        end
      end
    end
    // trailing bytes after the end marker are dropped by the block
    if (terminate)
      repeat ($urandom_range(2))
        queue_raw(lzcd_pkg::byte_t'($urandom_range(255)), 1'b0);
  endtask

  task automatic queue_random(int target);
    int base;
    int pick;
    base = queued_count;
    while (queued_count - base < target) begin
      pick = $urandom_range(9);
      if (pick <= 6) begin
        queue_chunk($urandom_range(3, 1), $urandom_range(9) < 7);
      end else if (pick == 7) begin
        queue_chunk(1, 1'b0);
        repeat ($urandom_range(3, 1))
          queue_byte(lzcd_pkg::byte_t'($urandom_range(255)), 1'b0);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          queue_raw(lzcd_pkg::byte_t'($urandom_range(255)),
                    logic'($urandom_range(3) == 0));
          queued_count++;
        end
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (compressed_q.size() != 0 || in_if.valid || decoded_q.size() != 0)
      @(negedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_cfg(logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    descramble_on = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    chunk_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        decode_byte(in_if.in_byte, in_if.chunk_start);
      if (!in_if.valid || in_if.ready) begin
        if (compressed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = compressed_q[0];
          compressed_q.delete(0);
          in_if.valid <= 1'b1;
          in_if.in_byte <= nxt.data;
          in_if.chunk_start <= nxt.start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    decoded_t exp_res;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected transfer: out_byte %0h byte_valid %0b stream_end %0b",
                 out_if.out_byte, out_if.byte_valid, out_if.stream_end);
          err_count++;
        end else begin
          exp_res = decoded_q[0];
          decoded_q.delete(0);
          if (out_if.out_byte !== exp_res.data) begin
            $error("out_byte: expected %0h, got %0h", exp_res.data, out_if.out_byte);
            err_count++;
          end
          if (out_if.byte_valid !== exp_res.is_byte) begin
            $error("byte_valid: expected %0b, got %0b", exp_res.is_byte, out_if.byte_valid);
            err_count++;
          end
          if (out_if.run_last !== exp_res.last) begin
            $error("run_last: expected %0b, got %0b", exp_res.last, out_if.run_last);
            err_count++;
          end
          if (out_if.stream_end !== exp_res.fin) begin
            $error("stream_end: expected %0b, got %0b", exp_res.fin, out_if.stream_end);
            err_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.chunk_start = 1'b0;
    out_if.ready = 1'b0;
    foreach (window[i])
      window[i] = '0;
    wr_ptr = lzcd_pkg::win_addr_t'(1);
    flags = '0;
    flag_sel = 9'd1;
    phase = WANT_FLAGS;
    tok_lo = '0;
    pos = '0;
    descramble_on = 1'b0;
    gen_pos = '0;
    gen_wr = lzcd_pkg::win_addr_t'(1);
    queued_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    stall_cycles = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(1'b0);

    // literal, overlapping max-length copy, copy across the window wrap
    queue_byte(8'h06, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h01, 1'b0);
    // end marker, then bytes after the end
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // restart in the middle of a token
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h23, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h7E, 1'b0);
    queue_random(40);
    drain();

    write_cfg(1'b1);
    send_idle_pct = 87;
    queue_random(40);
    drain();

    write_cfg(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 87;
    queue_random(40);
    drain();

    write_cfg(1'b1);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    queue_random(40);
    drain();

    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/lzcd_pkg.sv
design/lzcd_if.sv
design/lzcd_ram.sv
design/lzcd_ctrl.sv
design/lzcd_dp.sv
design/lzss_chunk_decoder_top.sv
dv/tb_lzss_chunk_decoder_top.sv
